// ===== design/tmsaa_pkg.sv =====
// ----------------------------------------------------------------------------
// tmsaa_pkg
// Shared types and constants of the tiled multisample fetch and resolve block.
// ----------------------------------------------------------------------------
package tmsaa_pkg;

   // Fixed field widths
   localparam int ADDR_W  = 22;
   localparam int WORD_W  = 32;
   localparam int COORD_W = 13;
   localparam int CFG_W   = 11;
   localparam int COL_W   = 6;

   // Request opcodes
   localparam logic OP_WRITE   = 1'b0;
   localparam logic OP_RESOLVE = 1'b1;

   // Configuration register indexes
   localparam logic [1:0] REG_PITCH  = 2'd0;
   localparam logic [1:0] REG_BASE   = 2'd1;
   localparam logic [1:0] REG_LOADED = 2'd2;

   // Configuration reset values
   localparam logic [CFG_W-1:0]  PITCH_RESET  = 11'd1;
   localparam logic [CFG_W-1:0]  BASE_RESET   = 11'd0;
   localparam logic [ADDR_W-1:0] LOADED_RESET = 22'd2621440;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TILE,
      ST_FETCH,
      ST_RESOLVE
   } state_type;

   // Tile address result handed from the tile calculator to the sequencer
   typedef struct packed {
      logic              done;
      logic [ADDR_W-1:0] tile_base;
      logic [COL_W-1:0]  col;
   } tile_info_type;

endpackage

// ===== design/tmsaa_tile_calc.sv =====
// ----------------------------------------------------------------------------
// tmsaa_tile_calc
// Five-stage pipeline that turns a pixel position into the word address of
// its tile and the even column inside the tile. The tile index is reduced
// modulo the tile count by a reciprocal multiply and one correction step.
// ----------------------------------------------------------------------------
module tmsaa_tile_calc #(
   parameter int TILE_COUNT = 2048
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [tmsaa_pkg::COORD_W-1:0]  pixel_x,
   input  logic [tmsaa_pkg::COORD_W-1:0]  pixel_y,
   input  logic [tmsaa_pkg::CFG_W-1:0]    pitch,
   input  logic [tmsaa_pkg::CFG_W-1:0]    base,
   output tmsaa_pkg::tile_info_type       info
);

   localparam int SUM_W = tmsaa_pkg::ADDR_W;
   localparam int RCP_W = SUM_W + 1;
   localparam int TCW   = $clog2(TILE_COUNT + 1);
   localparam int RW    = TCW + 1;
   localparam logic [RCP_W-1:0]     RECIP = RCP_W'((64'd1 << SUM_W) / TILE_COUNT);
   localparam logic [SUM_W-1:0]     TC_S  = SUM_W'(TILE_COUNT);
   localparam logic [RW-1:0]        TC_R  = RW'(TILE_COUNT);

   logic [4:0]                       vld_ff;
   logic [20:0]                      prod_ff;
   logic [7:0]                       xq_ff;
   logic [11:0]                      xe_ff;
   logic [SUM_W-1:0]                 sum_ff;
   logic [tmsaa_pkg::COL_W-1:0]      col_ff;
   logic [SUM_W-1:0]                 qe_ff;
   logic [RW-1:0]                    rem_ff;
   logic [SUM_W-1:0]                 tile_base_ff;

   logic [20:0]                      prod_in;
   logic [17:0]                      xq_prod;
   logic [SUM_W-1:0]                 sum_in;
   logic [12:0]                      xe_full;
   logic [12:0]                      x40;
   logic [12:0]                      col_diff;
   logic [SUM_W+RCP_W-1:0]           rcp_prod;
   logic [SUM_W-1:0]                 qm;
   logic [SUM_W-1:0]                 rem_diff;
   logic [RW-1:0]                    tile_in;
   logic [SUM_W-1:0]                 tile_ext;

   // stage 1: tile row times pitch, tile column by reciprocal of five
   always_comb begin
      prod_in = {11'd0, pixel_y[12:3]} * {10'd0, pitch};
      xq_prod = {8'd0, pixel_x[12:3]} * 18'd205;
   end

   // stage 2: unreduced tile index and column inside the tile
   always_comb begin
      sum_in   = {1'b0, prod_ff} + {11'd0, base} + {14'd0, xq_ff};
      xe_full  = {xe_ff, 1'b0};
      x40      = {xq_ff, 5'b0} + {2'b0, xq_ff, 3'b0};
      col_diff = xe_full - x40;
   end

   // stage 3 and 4: estimated quotient, then remainder below twice the count
   always_comb begin
      rcp_prod = {{RCP_W{1'b0}}, sum_ff} * {{SUM_W{1'b0}}, RECIP};
      qm       = qe_ff * TC_S;
      rem_diff = sum_ff - qm;
   end

   // stage 5: final correction and scale by the tile size
   always_comb begin
      tile_in  = (rem_ff >= TC_R) ? (rem_ff - TC_R) : rem_ff;
      tile_ext = SUM_W'(tile_in);
   end

   // advance the stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[3:0], start};
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= prod_in;
         xq_ff   <= xq_prod[17:10];
         xe_ff   <= pixel_x[12:1];
      end
      if (vld_ff[0]) begin
         sum_ff <= sum_in;
         col_ff <= col_diff[tmsaa_pkg::COL_W-1:0];
      end
      if (vld_ff[1]) begin
         qe_ff <= rcp_prod[2*SUM_W-1:SUM_W];
      end
      if (vld_ff[2]) begin
         rem_ff <= rem_diff[RW-1:0];
      end
      if (vld_ff[3]) begin
         tile_base_ff <= (tile_ext << 10) + (tile_ext << 8);
      end
   end

   assign info.done      = vld_ff[4];
   assign info.tile_base = tile_base_ff;
   assign info.col       = col_ff;

endmodule

// ===== design/tiled_msaa_fetch_and_resolve.sv =====
// ----------------------------------------------------------------------------
// tiled_msaa_fetch_and_resolve
// Tiled 4x multisample store with per-pixel sample fetch and byte-wise
// rounded resolve.
// ----------------------------------------------------------------------------
// A write request is accepted while busy is low and is stored at once, with
// no response. A resolve request raises busy until the tile address pipeline
// and the fetch are done, and its response strobes on rsp_valid as busy falls,
// so a resolve must finish before the next one is taken. The sequence is the
// five-stage tile address pipeline followed by four registered reads of the
// single-port sample store, one per cycle. The
// response is shown for exactly one cycle and cannot be stalled, so the
// receiver must take every rsp_valid beat. Configuration writes take effect
// at the next edge and must only be made while busy is low.
// ----------------------------------------------------------------------------
module tiled_msaa_fetch_and_resolve #(
   parameter int TILE_COUNT = 2048
) (
   input  logic                           clock,
   input  logic                           reset,
   // request
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_opcode,
   input  logic [tmsaa_pkg::ADDR_W-1:0]   req_store_address,
   input  logic [tmsaa_pkg::WORD_W-1:0]   req_store_word,
   input  logic [tmsaa_pkg::COORD_W-1:0]  req_pixel_x,
   input  logic [tmsaa_pkg::COORD_W-1:0]  req_pixel_y,
   // response
   output logic                           rsp_valid,
   output logic [tmsaa_pkg::WORD_W-1:0]   rsp_sample_zero,
   output logic [tmsaa_pkg::WORD_W-1:0]   rsp_sample_one,
   output logic [tmsaa_pkg::WORD_W-1:0]   rsp_sample_two,
   output logic [tmsaa_pkg::WORD_W-1:0]   rsp_sample_three,
   output logic [tmsaa_pkg::WORD_W-1:0]   rsp_averaged_word,
   output logic                           rsp_addr_flagged,
   // configuration
   input  logic                           csr_we,
   input  logic [1:0]                     csr_index,
   input  logic [tmsaa_pkg::ADDR_W-1:0]   csr_wdata
);

   localparam int DEPTH = TILE_COUNT * 1280;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [tmsaa_pkg::ADDR_W-1:0] DEPTH_A = tmsaa_pkg::ADDR_W'(DEPTH);

   localparam int AD = tmsaa_pkg::ADDR_W;
   localparam int WD = tmsaa_pkg::WORD_W;

   tmsaa_pkg::state_type        state_ff;
   tmsaa_pkg::state_type        state_in;
   tmsaa_pkg::tile_info_type    tile_info;

   logic [WD-1:0]               store_mem [DEPTH];

   logic [tmsaa_pkg::CFG_W-1:0] pitch_ff;
   logic [tmsaa_pkg::CFG_W-1:0] base_ff;
   logic [AD-1:0]               loaded_ff;

   logic                        x0_ff;
   logic [2:0]                  ylo_ff;
   logic [2:0]                  cnt_ff;
   logic [AD-1:0]               addr_ff;
   logic [1:0]                  aidx_ff;
   logic                        avld_ff;
   logic [WD-1:0]               rdata_ff;
   logic [1:0]                  ridx_ff;
   logic                        rvld_ff;
   logic                        flag_ff;
   logic [WD-1:0]               samp_ff [4];

   logic                        rsp_valid_ff;
   logic [WD-1:0]               rsp_samp_ff [4];
   logic [WD-1:0]               rsp_avg_ff;
   logic                        rsp_flag_ff;

   logic                        accept;
   logic                        gen_en;
   logic                        resolve_en;
   logic                        last_beat;
   logic [10:0]                 offset;
   logic [WD-1:0]               avg_in;

   // swap sample indices one and two
   function automatic logic [1:0] swap_one_two(input logic [1:0] v);
      logic [1:0] r;
      begin
         r = ((v == 2'd1) || (v == 2'd2)) ? (v ^ 2'd3) : v;
         return r;
      end
   endfunction

   // word offset of one sample inside its tile
   function automatic logic [10:0] sample_offset(
      input logic                          x0,
      input logic [2:0]                    ylo,
      input logic [tmsaa_pkg::COL_W-1:0]   col,
      input logic [1:0]                    s
   );
      logic [1:0]  sx;
      logic [1:0]  sy;
      logic [3:0]  row;
      logic [9:0]  lin;
      begin
         sx  = swap_one_two({x0, s[1]});
         sy  = swap_one_two({ylo[0], s[0]});
         row = {ylo[2:1], sy};
         lin = {1'b0, row, 5'b0} + {3'b0, row, 3'b0} + {4'b0, col};
         return {lin, 1'b0} + {9'd0, sx};
      end
   endfunction

   assign accept = start && !busy;

   // tile address pipeline
   tmsaa_tile_calc #(
      .TILE_COUNT (TILE_COUNT)
   ) u_tile_calc (
      .clock   (clock),
      .reset   (reset),
      .start   (accept && (req_opcode == tmsaa_pkg::OP_RESOLVE)),
      .pixel_x (req_pixel_x),
      .pixel_y (req_pixel_y),
      .pitch   (pitch_ff),
      .base    (base_ff),
      .info    (tile_info)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_ff  <= tmsaa_pkg::PITCH_RESET;
         base_ff   <= tmsaa_pkg::BASE_RESET;
         loaded_ff <= tmsaa_pkg::LOADED_RESET;
      end else if (csr_we) begin
         case (csr_index)
            tmsaa_pkg::REG_PITCH:  pitch_ff  <= csr_wdata[tmsaa_pkg::CFG_W-1:0];
            tmsaa_pkg::REG_BASE:   base_ff   <= csr_wdata[tmsaa_pkg::CFG_W-1:0];
            tmsaa_pkg::REG_LOADED: loaded_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tmsaa_pkg::ST_IDLE: begin
            if (accept && (req_opcode == tmsaa_pkg::OP_RESOLVE)) begin
               state_in = tmsaa_pkg::ST_TILE;
            end
         end
         tmsaa_pkg::ST_TILE: begin
            if (tile_info.done) begin
               state_in = tmsaa_pkg::ST_FETCH;
            end
         end
         tmsaa_pkg::ST_FETCH: begin
            if (last_beat) begin
               state_in = tmsaa_pkg::ST_RESOLVE;
            end
         end
         tmsaa_pkg::ST_RESOLVE: state_in = tmsaa_pkg::ST_IDLE;
         default:               state_in = tmsaa_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      busy       = 1'b1;
      gen_en     = 1'b0;
      resolve_en = 1'b0;
      case (state_ff)
         tmsaa_pkg::ST_IDLE:    busy       = 1'b0;
         tmsaa_pkg::ST_TILE:    busy       = 1'b1;
         tmsaa_pkg::ST_FETCH:   gen_en     = !cnt_ff[2];
         tmsaa_pkg::ST_RESOLVE: resolve_en = 1'b1;
         default:               busy       = 1'b1;
      endcase
   end

   assign last_beat = rvld_ff && (ridx_ff == 2'd3);
   assign offset    = sample_offset(x0_ff, ylo_ff, tile_info.col, cnt_ff[1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tmsaa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // hold pixel low bits for the sample offsets
   always_ff @(posedge clock) begin
      if (accept) begin
         x0_ff  <= req_pixel_x[0];
         ylo_ff <= req_pixel_y[2:0];
      end
   end

   // sample address generation and read pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         avld_ff <= 1'b0;
         rvld_ff <= 1'b0;
         flag_ff <= 1'b0;
      end else begin
         avld_ff <= gen_en;
         rvld_ff <= avld_ff;
         if (accept) begin
            cnt_ff  <= '0;
            flag_ff <= 1'b0;
         end else begin
            if (gen_en) begin
               cnt_ff <= cnt_ff + 3'd1;
            end
            if (avld_ff && (addr_ff >= loaded_ff)) begin
               flag_ff <= 1'b1;
            end
         end
      end
   end

   // address and index payload
   always_ff @(posedge clock) begin
      if (gen_en) begin
         addr_ff <= tile_info.tile_base + {11'd0, offset};
         aidx_ff <= cnt_ff[1:0];
      end
      if (avld_ff) begin
         ridx_ff <= aidx_ff;
      end
      if (rvld_ff) begin
         samp_ff[ridx_ff] <= rdata_ff;
      end
   end

   // sample store: write beats from idle, one registered read per fetch beat
   always_ff @(posedge clock) begin
      if (accept && (req_opcode == tmsaa_pkg::OP_WRITE) && (req_store_address < DEPTH_A)) begin
         store_mem[req_store_address[AW-1:0]] <= req_store_word;
      end
      if (avld_ff) begin
         rdata_ff <= store_mem[addr_ff[AW-1:0]];
      end
   end

   // byte-wise rounded mean of the four samples
   always_comb begin
      avg_in = '0;
      for (int c = 0; c < 4; c++) begin
         logic [9:0] sum;
         sum = 10'd2
             + {2'b0, samp_ff[0][8*c +: 8]} + {2'b0, samp_ff[1][8*c +: 8]}
             + {2'b0, samp_ff[2][8*c +: 8]} + {2'b0, samp_ff[3][8*c +: 8]};
         avg_in[8*c +: 8] = sum[9:2];
      end
   end

   // response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= resolve_en;
      end
   end

   // response payload, zeroed when any sample address is flagged
   always_ff @(posedge clock) begin
      if (resolve_en) begin
         for (int s = 0; s < 4; s++) begin
            rsp_samp_ff[s] <= flag_ff ? '0 : samp_ff[s];
         end
         rsp_avg_ff  <= flag_ff ? '0 : avg_in;
         rsp_flag_ff <= flag_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample_zero   = rsp_samp_ff[0];
   assign rsp_sample_one    = rsp_samp_ff[1];
   assign rsp_sample_two    = rsp_samp_ff[2];
   assign rsp_sample_three  = rsp_samp_ff[3];
   assign rsp_averaged_word = rsp_avg_ff;
   assign rsp_addr_flagged  = rsp_flag_ff;

endmodule

// ===== tb/sv/tiled_msaa_fetch_and_resolve_tb.sv =====
// ----------------------------------------------------------------------------
// tiled_msaa_fetch_and_resolve_tb
// Self-checking bench for the tiled 4x multisample fetch and resolve block.
// A short table of directed beats runs first: full-scale and mixed sample
// words, writes past the end of the store, flagged addresses, pitch zero and
// wrapped tile bases. Random phases follow, each under its own register
// setting. Every resolve beat is checked against the table's own result, or
// else a local model of the tile addressing and the byte-wise rounded mean.
// Every resolved pixel has all four of its samples written first.
// ----------------------------------------------------------------------------
module tiled_msaa_fetch_and_resolve_tb;

   localparam int ADDR_W       = tmsaa_pkg::ADDR_W;
   localparam int WORD_W       = tmsaa_pkg::WORD_W;
   localparam int COORD_W      = tmsaa_pkg::COORD_W;
   localparam int CFG_W        = tmsaa_pkg::CFG_W;

   localparam int TILES        = 2048;
   localparam int TILE_PIX_W   = 40;
   localparam int TILE_WORDS   = 1280;
   localparam int STORE_WORDS  = TILES * TILE_WORDS;
   localparam int RANDOM_BEATS = 600;
   localparam int PHASE_COUNT  = 6;
   localparam int SETTLE_WAIT  = 4;
   localparam int DRAIN_LIMIT  = 4000;
   localparam int TAIL_WAIT    = 20;

   // register index the block does not decode
   localparam logic [1:0] REG_UNUSED = 2'd3;

   typedef enum int {ROW_WRITE, ROW_RESOLVE, ROW_FILL, ROW_CFG} row_kind_type;

   typedef struct packed {
      logic [3:0][WORD_W-1:0] smp;
      logic [WORD_W-1:0]      avg;
      logic                   oor;
   } resolve_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } pixel_type;

   typedef struct {
      row_kind_type       kind;
      logic [31:0]        a;
      logic [31:0]        b;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               chk;
      resolve_type        want;
   } dir_row_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_opcode;
   logic [ADDR_W-1:0]   req_store_address;
   logic [WORD_W-1:0]   req_store_word;
   logic [COORD_W-1:0]  req_pixel_x;
   logic [COORD_W-1:0]  req_pixel_y;
   logic                rsp_valid;
   logic [WORD_W-1:0]   rsp_sample_zero;
   logic [WORD_W-1:0]   rsp_sample_one;
   logic [WORD_W-1:0]   rsp_sample_two;
   logic [WORD_W-1:0]   rsp_sample_three;
   logic [WORD_W-1:0]   rsp_averaged_word;
   logic                rsp_addr_flagged;
   logic                csr_we;
   logic [1:0]          csr_index;
   logic [ADDR_W-1:0]   csr_wdata;

   // local copy of the registers and the sample store
   int unsigned         pitch_q;
   int unsigned         base_q;
   int unsigned         loaded_q;
   logic [WORD_W-1:0]   shadow_store [int unsigned];

   resolve_type         pending_resolves [$];
   pixel_type           filled_pixels [$];
   dir_row_type         dir_table [$];

   int                  errors;
   int                  beats_sent;
   int                  resolves_sent;
   int                  resolves_seen;
   int                  flagged_seen;
   int                  reg_writes;
   bit                  steady;

   tiled_msaa_fetch_and_resolve #(
      .TILE_COUNT(TILES)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_store_address (req_store_address),
      .req_store_word    (req_store_word),
      .req_pixel_x       (req_pixel_x),
      .req_pixel_y       (req_pixel_y),
      .rsp_valid         (rsp_valid),
      .rsp_sample_zero   (rsp_sample_zero),
      .rsp_sample_one    (rsp_sample_one),
      .rsp_sample_two    (rsp_sample_two),
      .rsp_sample_three  (rsp_sample_three),
      .rsp_averaged_word (rsp_averaged_word),
      .rsp_addr_flagged  (rsp_addr_flagged),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #5 clock = ~clock;

   // swap sample indexes 1 and 2, keep 0 and 3
   function automatic int unsigned swizzle(input int unsigned v);
      return (v == 1 || v == 2) ? (v ^ 3) : v;
   endfunction

   // word address of sample s of pixel (x, y) under the current registers
   function automatic int unsigned sample_addr(input int unsigned x, input int unsigned y,
                                               input int unsigned s);
      int unsigned sx, sy, row, col, tile;
      sx   = swizzle(((x & 1) << 1) + (s >> 1));
      sy   = swizzle(((y & 1) << 1) | (s & 1));
      row  = sy | ((y << 1) & 12);
      col  = (x & 32'hFFFF_FFFE) % TILE_PIX_W;
      tile = ((y >> 3) * pitch_q + base_q + x / TILE_PIX_W) % TILES;
      return tile * TILE_WORDS + 2 * (row * TILE_PIX_W + col) + sx;
   endfunction

   // fetch the four samples and average each byte lane, rounding half up; a flagged address zeroes samples and mean
   function automatic resolve_type predict_resolve(input logic [COORD_W-1:0] x,
                                                   input logic [COORD_W-1:0] y);
      resolve_type r;
      int unsigned a;
      int unsigned sum;
      r = '0;
      for (int s = 0; s < 4; s++) begin
         a = sample_addr(x, y, s);
         if (a >= loaded_q) r.oor = 1'b1;
         r.smp[s] = shadow_store.exists(a) ? shadow_store[a] : '0;
      end
      if (r.oor) begin
         r.smp = '0;
      end else begin
         for (int c = 0; c < 32; c += 8) begin
            sum = 2;
            for (int s = 0; s < 4; s++) sum += (r.smp[s] >> c) & 8'hFF;
            r.avg[c +: 8] = 8'((sum >> 2) & 8'hFF);
         end
      end
      return r;
   endfunction

   function automatic resolve_type typed_result(input logic [31:0] s0, input logic [31:0] s1,
                                                input logic [31:0] s2, input logic [31:0] s3,
                                                input logic [31:0] avg, input logic oor);
      resolve_type r;
      r.smp[0] = s0;
      r.smp[1] = s1;
      r.smp[2] = s2;
      r.smp[3] = s3;
      r.avg    = avg;
      r.oor    = oor;
      return r;
   endfunction

   function automatic dir_row_type mk_row(input row_kind_type kind, input logic [31:0] a,
                                          input logic [31:0] b, input int unsigned x = 0,
                                          input int unsigned y = 0, input logic chk = 1'b0,
                                          input resolve_type want = '0);
      dir_row_type r;
      r.kind = kind;
      r.a    = a;
      r.b    = b;
      r.x    = COORD_W'(x);
      r.y    = COORD_W'(y);
      r.chk  = chk;
      r.want = want;
      return r;
   endfunction

   // mostly random words, with all-zero and all-one lanes now and then
   function automatic logic [WORD_W-1:0] random_word();
      int unsigned pick;
      pick = $urandom_range(7);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return WORD_W'($urandom);
   endfunction

   // mostly random coordinates, with the edges now and then
   function automatic logic [COORD_W-1:0] pick_coord();
      int unsigned pick;
      pick = $urandom_range(9);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return COORD_W'($urandom);
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   // drive one beat, hold it until accepted, then update the local model
   task automatic send_beat(input logic op, input logic [ADDR_W-1:0] addr,
                            input logic [WORD_W-1:0] word, input logic [COORD_W-1:0] x,
                            input logic [COORD_W-1:0] y, input logic chk = 1'b0,
                            input resolve_type want = '0);
      // unless steady, idle one step at a time, with a chance of 36 in 100 each
      if (!steady) begin
         while ($urandom_range(99) < 36) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start             <= 1'b1;
      req_opcode        <= op;
      req_store_address <= addr;
      req_store_word    <= word;
      req_pixel_x       <= x;
      req_pixel_y       <= y;
      do @(posedge clock); while (busy);
      beats_sent++;
      if (op == tmsaa_pkg::OP_WRITE) begin
         if (addr < STORE_WORDS) shadow_store[addr] = word;
      end else begin
         pending_resolves.push_back(chk ? want : predict_resolve(x, y));
         resolves_sent++;
      end
   endtask

   // hold off until all results are back and the block is idle
   task automatic settle();
      start <= 1'b0;
      while (pending_resolves.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [ADDR_W-1:0] val);
      settle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      reg_writes++;
      case (idx)
         tmsaa_pkg::REG_PITCH:  pitch_q  = val[CFG_W-1:0];
         tmsaa_pkg::REG_BASE:   base_q   = val[CFG_W-1:0];
         tmsaa_pkg::REG_LOADED: loaded_q = val;
         default: ;
      endcase
   endtask

   // write all four samples of a pixel in rotated order, then resolve it
   task automatic fill_and_resolve(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
      int unsigned rot;
      pixel_type   p;
      rot = $urandom_range(3);
      for (int k = 0; k < 4; k++) begin
         if ($urandom_range(9) == 0)
            send_beat(tmsaa_pkg::OP_WRITE, ADDR_W'($urandom), random_word(), pick_coord(),
                      pick_coord());
         send_beat(tmsaa_pkg::OP_WRITE, ADDR_W'(sample_addr(x, y, (k + rot) % 4)),
                   random_word(), pick_coord(), pick_coord());
      end
      send_beat(tmsaa_pkg::OP_RESOLVE, ADDR_W'($urandom), WORD_W'($urandom), x, y);
      p.x = x;
      p.y = y;
      filled_pixels.push_back(p);
   endtask

   // compare every result beat with the oldest prediction
   always @(posedge clock) begin
      resolve_type want;
      resolve_type got;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_resolves.size() == 0) begin
            $display("%0t: result beat with no resolve outstanding, actual avg %h",
                     $time, rsp_averaged_word);
            errors++;
         end else begin
            want       = pending_resolves.pop_front();
            got.smp[0] = rsp_sample_zero;
            got.smp[1] = rsp_sample_one;
            got.smp[2] = rsp_sample_two;
            got.smp[3] = rsp_sample_three;
            got.avg    = rsp_averaged_word;
            got.oor    = rsp_addr_flagged;
            for (int s = 0; s < 4; s++)
               check_field($sformatf("sample %0d", s), want.smp[s], got.smp[s]);
            check_field("averaged_word", want.avg, got.avg);
            check_field("addr_flagged", 32'(want.oor), 32'(got.oor));
            resolves_seen++;
            if (want.oor) flagged_seen++;
         end
      end
   end

   // give up if the run hangs
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      int unsigned random_start;
      int          phase_end;
      int unsigned pick;
      pixel_type   p;

      clock             = 1'b0;
      reset             = 1'b1;
      start             = 1'b0;
      req_opcode        = tmsaa_pkg::OP_WRITE;
      req_store_address = '0;
      req_store_word    = '0;
      req_pixel_x       = '0;
      req_pixel_y       = '0;
      csr_we            = 1'b0;
      csr_index         = tmsaa_pkg::REG_PITCH;
      csr_wdata         = '0;
      pitch_q           = tmsaa_pkg::PITCH_RESET;
      base_q            = tmsaa_pkg::BASE_RESET;
      loaded_q          = tmsaa_pkg::LOADED_RESET;
      errors            = 0;
      beats_sent        = 0;
      resolves_sent     = 0;
      resolves_seen     = 0;
      flagged_seen      = 0;
      reg_writes        = 0;
      steady            = 1'b0;

      // pixel (0,0) at reset settings reads words 0, 160, 2 and 162
      dir_table.push_back(mk_row(ROW_WRITE, 0, 32'hFFFF_FFFF));
      dir_table.push_back(mk_row(ROW_WRITE, 160, 32'hFFFF_FFFF));
      dir_table.push_back(mk_row(ROW_WRITE, 2, 32'hFFFF_FFFF));
      dir_table.push_back(mk_row(ROW_WRITE, 162, 32'hFFFF_FFFF));
      dir_table.push_back(mk_row(ROW_RESOLVE, 0, 0, 0, 0, 1'b1,
         typed_result('1, '1, '1, '1, '1, 1'b0)));
      dir_table.push_back(mk_row(ROW_WRITE, 160, 32'h0));
      dir_table.push_back(mk_row(ROW_WRITE, 162, 32'h0));
      dir_table.push_back(mk_row(ROW_RESOLVE, 0, 0, 0, 0, 1'b1,
         typed_result('1, '0, '1, '0, 32'h8080_8080, 1'b0)));
      // writes past the end of the store are dropped
      dir_table.push_back(mk_row(ROW_WRITE, 32'h3F_FFFF, 32'hDEAD_BEEF));
      dir_table.push_back(mk_row(ROW_FILL, 0, 0, 8191, 8191));
      // flagged addresses zero every sample and the mean
      dir_table.push_back(mk_row(ROW_CFG, tmsaa_pkg::REG_LOADED, 0));
      dir_table.push_back(mk_row(ROW_RESOLVE, 0, 0, 0, 0, 1'b1,
         typed_result('0, '0, '0, '0, '0, 1'b1)));
      dir_table.push_back(mk_row(ROW_CFG, tmsaa_pkg::REG_LOADED, 161));
      dir_table.push_back(mk_row(ROW_RESOLVE, 0, 0, 0, 0));
      dir_table.push_back(mk_row(ROW_CFG, tmsaa_pkg::REG_LOADED, 163));
      dir_table.push_back(mk_row(ROW_RESOLVE, 0, 0, 0, 0));
      dir_table.push_back(mk_row(ROW_CFG, REG_UNUSED, 32'h3F_FFFF));
      dir_table.push_back(mk_row(ROW_CFG, tmsaa_pkg::REG_LOADED, 32'h3F_FFFF));
      // pitch zero folds every tile row onto the first
      dir_table.push_back(mk_row(ROW_CFG, tmsaa_pkg::REG_PITCH, 0));
      dir_table.push_back(mk_row(ROW_FILL, 0, 0, 100, 4000));
      // largest pitch and base wrap around the tile count
      dir_table.push_back(mk_row(ROW_CFG, tmsaa_pkg::REG_PITCH, 32'h3F_FFFF));
      dir_table.push_back(mk_row(ROW_CFG, tmsaa_pkg::REG_BASE, 32'h7FF));
      dir_table.push_back(mk_row(ROW_FILL, 0, 0, 8191, 8191));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the directed table
      foreach (dir_table[i]) begin
         case (dir_table[i].kind)
            ROW_WRITE:
               send_beat(tmsaa_pkg::OP_WRITE, dir_table[i].a[ADDR_W-1:0], dir_table[i].b,
                         pick_coord(), pick_coord());
            ROW_RESOLVE:
               send_beat(tmsaa_pkg::OP_RESOLVE, ADDR_W'($urandom), WORD_W'($urandom),
                         dir_table[i].x, dir_table[i].y, dir_table[i].chk, dir_table[i].want);
            ROW_FILL:
               fill_and_resolve(dir_table[i].x, dir_table[i].y);
            ROW_CFG:
               write_reg(dir_table[i].a[1:0], dir_table[i].b[ADDR_W-1:0]);
            default: ;
         endcase
      end

      // random phases, one register setting each
      random_start = beats_sent;
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         case (ph)
            0: begin
               write_reg(tmsaa_pkg::REG_PITCH, ADDR_W'(tmsaa_pkg::PITCH_RESET));
               write_reg(tmsaa_pkg::REG_BASE, ADDR_W'(tmsaa_pkg::BASE_RESET));
               write_reg(tmsaa_pkg::REG_LOADED, tmsaa_pkg::LOADED_RESET);
            end
            1: begin
               write_reg(tmsaa_pkg::REG_PITCH, 22'h3F_FFFF);
               write_reg(tmsaa_pkg::REG_BASE, 22'h3F_FFFF);
               write_reg(tmsaa_pkg::REG_LOADED, 22'h3F_FFFF);
            end
            2: begin
               write_reg(tmsaa_pkg::REG_PITCH, 22'h0);
               write_reg(tmsaa_pkg::REG_BASE, ADDR_W'($urandom));
               write_reg(tmsaa_pkg::REG_LOADED, tmsaa_pkg::LOADED_RESET);
            end
            3: begin
               write_reg(tmsaa_pkg::REG_PITCH, ADDR_W'($urandom));
               write_reg(tmsaa_pkg::REG_BASE, ADDR_W'($urandom));
               write_reg(tmsaa_pkg::REG_LOADED, ADDR_W'($urandom_range(0, STORE_WORDS)));
               write_reg(REG_UNUSED, ADDR_W'($urandom));
            end
            4: begin
               write_reg(tmsaa_pkg::REG_PITCH, ADDR_W'($urandom_range(1, 8)));
               write_reg(tmsaa_pkg::REG_BASE, ADDR_W'($urandom));
               write_reg(tmsaa_pkg::REG_LOADED,
                         ADDR_W'($urandom_range(0, STORE_WORDS / 4)));
            end
            default: begin
               write_reg(tmsaa_pkg::REG_PITCH, ADDR_W'($urandom));
               write_reg(tmsaa_pkg::REG_BASE, ADDR_W'($urandom));
               write_reg(tmsaa_pkg::REG_LOADED, ADDR_W'($urandom));
            end
         endcase
         // addresses move with the registers, so forget earlier pixels
         filled_pixels.delete();
         phase_end = beats_sent + RANDOM_BEATS / PHASE_COUNT;
         while (beats_sent < phase_end) begin
            steady = (beats_sent - random_start >= 200) && (beats_sent - random_start < 320);
            pick = $urandom_range(99);
            if (pick < 60) begin
               fill_and_resolve(pick_coord(), pick_coord());
            end else if (pick < 80 && filled_pixels.size() != 0) begin
               p = filled_pixels[$urandom_range(filled_pixels.size() - 1)];
               send_beat(tmsaa_pkg::OP_RESOLVE, ADDR_W'($urandom), WORD_W'($urandom),
                         p.x, p.y);
            end else begin
               send_beat(tmsaa_pkg::OP_WRITE, ADDR_W'($urandom), random_word(),
                         pick_coord(), pick_coord());
            end
         end
      end
      steady = 1'b0;

      // drain the outstanding results
      start <= 1'b0;
      for (int i = 0; i < DRAIN_LIMIT && pending_resolves.size() != 0; i++)
         @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
      if (pending_resolves.size() != 0) begin
         $display("%0t: %0d resolve results never arrived", $time, pending_resolves.size());
         errors += pending_resolves.size();
      end

      $display("Drove %0d beats with %0d resolves and %0d register writes;",
               beats_sent, resolves_sent, reg_writes);
      $display("checked %0d resolve results, %0d of them with a flagged address.",
               resolves_seen, flagged_seen);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/tmsaa_pkg.sv
design/tmsaa_tile_calc.sv
design/tiled_msaa_fetch_and_resolve.sv
tb/sv/tiled_msaa_fetch_and_resolve_tb.sv
